### hw/rtl/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// shared types and widths for the tetrahedron circumcenter pipeline
// ----------------------------------------------------------------------------
package tcc_pkg;

    localparam int CW   = 32;   // coordinate width
    localparam int DW   = 33;   // edge vector width
    localparam int CRW  = 66;   // cross product and squared length width
    localparam int NUMW = 134;  // numerator width
    localparam int DENW = 101;  // denominator width
    localparam int N2W  = 135;  // rounding dividend width
    localparam int D2W  = 101;  // rounding divisor width
    localparam int QB   = 35;   // quotient bits
    localparam int REMW = 101;  // remainder width
    localparam int SW   = 37;   // final sum width

    typedef logic signed [NUMW-1:0] num_t;
    typedef logic signed [DENW-1:0] den_t;

    typedef struct packed {
        logic signed [CW-1:0] a_x;
        logic signed [CW-1:0] a_y;
        logic signed [CW-1:0] a_z;
        logic signed [CW-1:0] b_x;
        logic signed [CW-1:0] b_y;
        logic signed [CW-1:0] b_z;
        logic signed [CW-1:0] c_x;
        logic signed [CW-1:0] c_y;
        logic signed [CW-1:0] c_z;
        logic signed [CW-1:0] d_x;
        logic signed [CW-1:0] d_y;
        logic signed [CW-1:0] d_z;
    } tcc_in_t;

    typedef struct packed {
        logic signed [CW-1:0] out_x;
        logic signed [CW-1:0] out_y;
        logic signed [CW-1:0] out_z;
        logic                 degenerate;
        logic                 overflow;
    } tcc_out_t;

    typedef struct packed {
        logic [2:0][NUMW-1:0] num;
        logic [DENW-1:0]      den;
        logic [2:0][CW-1:0]   a;
    } tcc_nd_t;

    typedef struct packed {
        logic [D2W-1:0]        d2;
        logic                  deg;
        logic [2:0][REMW-1:0]  rem;
        logic [2:0][QB-1:0]    nlo;
        logic [2:0][QB-1:0]    q;
        logic [2:0]            neg;
        logic [2:0]            big;
        logic [2:0][CW-1:0]    a;
    } tcc_div_t;

endpackage

### hw/rtl/tcc_front.sv
// ----------------------------------------------------------------------------
// tcc_front
// edge vectors, cross products, squared lengths, numerator and denominator
// ----------------------------------------------------------------------------
module tcc_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  tcc_pkg::tcc_in_t in_data,
    output logic             out_valid,
    output tcc_pkg::tcc_nd_t nd
);
    import tcc_pkg::*;

    logic signed [CW-1:0] vtx [4][3];

    assign vtx[0][0] = in_data.a_x;
    assign vtx[0][1] = in_data.a_y;
    assign vtx[0][2] = in_data.a_z;
    assign vtx[1][0] = in_data.b_x;
    assign vtx[1][1] = in_data.b_y;
    assign vtx[1][2] = in_data.b_z;
    assign vtx[2][0] = in_data.c_x;
    assign vtx[2][1] = in_data.c_y;
    assign vtx[2][2] = in_data.c_z;
    assign vtx[3][0] = in_data.d_x;
    assign vtx[3][1] = in_data.d_y;
    assign vtx[3][2] = in_data.d_z;

    // stage 1: edges ba, ca, da
    logic                 v1_reg;
    logic signed [DW-1:0] e1_reg [3][3];
    logic signed [CW-1:0] a1_reg [3];

    // stage 2: products
    logic                  v2_reg;
    logic signed [CRW-1:0] p2_reg [3][3];
    logic signed [CRW-1:0] q2_reg [3][3];
    logic [CRW-1:0]        sq2_reg [3][3];
    logic signed [DW-1:0]  ba2_reg [3];
    logic signed [CW-1:0]  a2_reg [3];
    logic signed [CRW-1:0] p2_next [3][3];
    logic signed [CRW-1:0] q2_next [3][3];
    logic signed [CRW-1:0] sq2_next [3][3];

    // stage 3: cross products and squared lengths
    logic                  v3_reg;
    logic signed [CRW-1:0] c3_reg [3][3];
    logic [CRW-1:0]        s3_reg [3];
    logic signed [DW-1:0]  ba3_reg [3];
    logic signed [CW-1:0]  a3_reg [3];

    // stage 4: partial products
    logic               v4_reg;
    logic [66:0]        ll4_reg [3][3];
    logic [66:0]        lh4_reg [3][3];
    logic signed [65:0] hl4_reg [3][3];
    logic signed [65:0] hh4_reg [3][3];
    logic signed [67:0] dl4_reg [3];
    logic signed [64:0] dh4_reg [3];
    logic signed [CW-1:0] a4_reg [3];
    logic [66:0]        ll4_next [3][3];
    logic [66:0]        lh4_next [3][3];
    logic signed [65:0] hl4_next [3][3];
    logic signed [65:0] hh4_next [3][3];
    logic signed [67:0] dl4_next [3];
    logic signed [64:0] dh4_next [3];

    // stage 5: terms
    logic  v5_reg;
    num_t  nt5_reg [3][3];
    den_t  dt5_reg [3];
    logic signed [CW-1:0] a5_reg [3];

    // stage 6: sums
    logic    v6_reg;
    tcc_nd_t nd_reg;

    genvar j, k;
    generate
        for (j = 0; j < 3; j++)
        begin : g_pair
            localparam int UI = (j == 0) ? 0 : ((j == 1) ? 2 : 1);
            localparam int VI = (j == 0) ? 1 : ((j == 1) ? 0 : 2);
            for (k = 0; k < 3; k++)
            begin : g_comp
                localparam int K1 = (k + 1) % 3;
                localparam int K2 = (k + 2) % 3;
                assign p2_next[j][k]  = e1_reg[UI][K1] * e1_reg[VI][K2];
                assign q2_next[j][k]  = e1_reg[UI][K2] * e1_reg[VI][K1];
                assign sq2_next[j][k] = e1_reg[j][k] * e1_reg[j][k];
                // coordinate j, term k: c_k * s_(2-k)
                assign ll4_next[j][k] = c3_reg[k][j][33:0] * s3_reg[2-k][32:0];
                assign lh4_next[j][k] = c3_reg[k][j][33:0] * s3_reg[2-k][65:33];
                assign hl4_next[j][k] = $signed(c3_reg[k][j][65:34])
                                      * $signed({1'b0, s3_reg[2-k][32:0]});
                assign hh4_next[j][k] = $signed(c3_reg[k][j][65:34])
                                      * $signed({1'b0, s3_reg[2-k][65:33]});
            end
            assign dl4_next[j] = ba3_reg[j] * $signed({1'b0, c3_reg[2][j][33:0]});
            assign dh4_next[j] = ba3_reg[j] * $signed(c3_reg[2][j][65:34]);
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int m = 0; m < 3; m++)
                begin
                    e1_reg[i][m]  <= DW'(vtx[i+1][m]) - DW'(vtx[0][m]);
                    p2_reg[i][m]  <= p2_next[i][m];
                    q2_reg[i][m]  <= q2_next[i][m];
                    sq2_reg[i][m] <= sq2_next[i][m];
                    c3_reg[i][m]  <= p2_reg[i][m] - q2_reg[i][m];
                    ll4_reg[i][m] <= ll4_next[i][m];
                    lh4_reg[i][m] <= lh4_next[i][m];
                    hl4_reg[i][m] <= hl4_next[i][m];
                    hh4_reg[i][m] <= hh4_next[i][m];
                    nt5_reg[i][m] <= num_t'(ll4_reg[i][m])
                                   + (num_t'(lh4_reg[i][m]) <<< 33)
                                   + (num_t'(hl4_reg[i][m]) <<< 34)
                                   + (num_t'(hh4_reg[i][m]) <<< 67);
                end
                a1_reg[i]  <= vtx[0][i];
                a2_reg[i]  <= a1_reg[i];
                a3_reg[i]  <= a2_reg[i];
                a4_reg[i]  <= a3_reg[i];
                a5_reg[i]  <= a4_reg[i];
                ba2_reg[i] <= e1_reg[0][i];
                ba3_reg[i] <= ba2_reg[i];
                s3_reg[i]  <= sq2_reg[i][0] + sq2_reg[i][1] + sq2_reg[i][2];
                dl4_reg[i] <= dl4_next[i];
                dh4_reg[i] <= dh4_next[i];
                dt5_reg[i] <= den_t'(dl4_reg[i]) + (den_t'(dh4_reg[i]) <<< 34);
                nd_reg.num[i] <= nt5_reg[i][0] + nt5_reg[i][1] + nt5_reg[i][2];
                nd_reg.a[i]   <= a5_reg[i];
            end
            nd_reg.den <= (dt5_reg[0] + dt5_reg[1] + dt5_reg[2]) <<< 1;
        end
    end

    assign out_valid = v6_reg;
    assign nd        = nd_reg;

endmodule

### hw/rtl/tcc_norm.sv
// ----------------------------------------------------------------------------
// tcc_norm
// magnitudes, rounding offset and range check ahead of the divider
// ----------------------------------------------------------------------------
module tcc_norm (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  tcc_pkg::tcc_nd_t  nd,
    output logic              out_valid,
    output tcc_pkg::tcc_div_t dv
);
    import tcc_pkg::*;

    logic              v7_reg;
    logic [NUMW-2:0]   an7_reg [3];
    logic [DENW-2:0]   ad7_reg;
    logic [2:0]        neg7_reg;
    logic              deg7_reg;
    logic [2:0][CW-1:0] a7_reg;

    logic              v8_reg;
    logic [N2W-1:0]    n2_8_reg [3];
    logic [D2W-1:0]    d2_8_reg;
    logic [2:0]        neg8_reg;
    logic              deg8_reg;
    logic [2:0][CW-1:0] a8_reg;

    logic              v9_reg;
    tcc_div_t          dv_reg;

    num_t num_in [3];
    num_t num_abs [3];
    den_t den_in;
    den_t den_abs;

    always_comb
    begin
        den_in  = $signed(nd.den);
        den_abs = den_in[DENW-1] ? -den_in : den_in;
        for (int i = 0; i < 3; i++)
        begin
            num_in[i]  = $signed(nd.num[i]);
            num_abs[i] = num_in[i][NUMW-1] ? -num_in[i] : num_in[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end
        else if (en)
        begin
            v7_reg <= in_valid;
            v8_reg <= v7_reg;
            v9_reg <= v8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ad7_reg  <= den_abs[DENW-2:0];
            deg7_reg <= (den_in == '0);
            a7_reg   <= nd.a;
            d2_8_reg <= {ad7_reg, 1'b0};
            deg8_reg <= deg7_reg;
            neg8_reg <= neg7_reg;
            a8_reg   <= a7_reg;
            dv_reg.d2  <= d2_8_reg;
            dv_reg.deg <= deg8_reg;
            dv_reg.neg <= neg8_reg;
            dv_reg.a   <= a8_reg;
            for (int i = 0; i < 3; i++)
            begin
                an7_reg[i]  <= num_abs[i][NUMW-2:0];
                neg7_reg[i] <= num_in[i][NUMW-1] ^ den_in[DENW-1];
                n2_8_reg[i] <= N2W'({an7_reg[i], 1'b0}) + N2W'(ad7_reg);
                dv_reg.big[i] <= ({1'b0, n2_8_reg[i]} >= {d2_8_reg, {QB{1'b0}}});
                dv_reg.rem[i] <= REMW'(n2_8_reg[i][N2W-1:QB]);
                dv_reg.nlo[i] <= n2_8_reg[i][QB-1:0];
                dv_reg.q[i]   <= '0;
            end
        end
    end

    assign out_valid = v9_reg;
    assign dv        = dv_reg;

endmodule

### hw/rtl/tcc_div_stage.sv
// ----------------------------------------------------------------------------
// tcc_div_stage
// one restoring division step for all three coordinates
// ----------------------------------------------------------------------------
module tcc_div_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  tcc_pkg::tcc_div_t d_in,
    output logic              out_valid,
    output tcc_pkg::tcc_div_t d_out
);
    import tcc_pkg::*;

    logic     valid_reg;
    tcc_div_t data_reg;
    tcc_div_t data_next;
    logic [REMW:0] trial [3];

    always_comb
    begin
        data_next = d_in;
        for (int i = 0; i < 3; i++)
        begin
            trial[i] = {d_in.rem[i], d_in.nlo[i][QB-1]};
            data_next.nlo[i] = {d_in.nlo[i][QB-2:0], 1'b0};
            if (trial[i] >= {1'b0, d_in.d2})
            begin
                data_next.rem[i] = REMW'(trial[i] - {1'b0, d_in.d2});
                data_next.q[i]   = {d_in.q[i][QB-2:0], 1'b1};
            end
            else
            begin
                data_next.rem[i] = REMW'(trial[i]);
                data_next.q[i]   = {d_in.q[i][QB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign d_out     = data_reg;

endmodule

### hw/rtl/tetrahedron_circumcenter.sv
// ----------------------------------------------------------------------------
// tetrahedron_circumcenter
// circumcenter of a tetrahedron, signed q16.16 in and out
// ----------------------------------------------------------------------------
// Fully pipelined: one tetrahedron per cycle while the output is not held. Six
// stages form the exact numerator and denominator, three
// prepare the rounded division, 35 one-bit restoring divider stages produce
// the quotient and a final stage adds vertex a and saturates. The whole
// pipeline advances together; in_ready drops only while a result is held at
// the output with out_ready low. A zero denominator gives a zero point with
// degenerate set; a clamped coordinate sets overflow.
module tetrahedron_circumcenter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tcc_pkg::tcc_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output tcc_pkg::tcc_out_t out_data
);
    import tcc_pkg::*;

    logic     en;
    logic     front_valid;
    tcc_nd_t  nd;
    logic     dval [QB+1];
    tcc_div_t dchain [QB+1];

    logic     out_valid_reg;
    tcc_out_t out_reg;
    tcc_out_t out_next;

    logic signed [SW-1:0] qs [3];
    logic signed [SW-1:0] sum [3];
    logic [CW-1:0]        res [3];
    logic [2:0]           ovf;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    tcc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .in_data  (in_data),
        .out_valid(front_valid),
        .nd       (nd)
    );

    tcc_norm u_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (front_valid),
        .nd       (nd),
        .out_valid(dval[0]),
        .dv       (dchain[0])
    );

    genvar s;
    generate
        for (s = 0; s < QB; s++)
        begin : g_div
            tcc_div_stage u_stage (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (en),
                .in_valid (dval[s]),
                .d_in     (dchain[s]),
                .out_valid(dval[s+1]),
                .d_out    (dchain[s+1])
            );
        end
    endgenerate

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qs[i]  = dchain[QB].neg[i] ? -SW'({1'b0, dchain[QB].q[i]})
                                       :  SW'({1'b0, dchain[QB].q[i]});
            sum[i] = qs[i] + SW'($signed(dchain[QB].a[i]));
            if (dchain[QB].big[i])
            begin
                ovf[i] = 1'b1;
                res[i] = dchain[QB].neg[i] ? {1'b1, {(CW-1){1'b0}}}
                                           : {1'b0, {(CW-1){1'b1}}};
            end
            else if ((&sum[i][SW-1:CW-1]) || !(|sum[i][SW-1:CW-1]))
            begin
                ovf[i] = 1'b0;
                res[i] = sum[i][CW-1:0];
            end
            else
            begin
                ovf[i] = 1'b1;
                res[i] = sum[i][SW-1] ? {1'b1, {(CW-1){1'b0}}}
                                      : {1'b0, {(CW-1){1'b1}}};
            end
        end
        if (dchain[QB].deg)
        begin
            out_next.out_x      = '0;
            out_next.out_y      = '0;
            out_next.out_z      = '0;
            out_next.degenerate = 1'b1;
            out_next.overflow   = 1'b0;
        end
        else
        begin
            out_next.out_x      = res[0];
            out_next.out_y      = res[1];
            out_next.out_z      = res[2];
            out_next.degenerate = 1'b0;
            out_next.overflow   = |ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dval[QB];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### hw/rtl/tcc_check.sv
// ----------------------------------------------------------------------------
// tcc_check
// port-level checks for the circumcenter pipeline, bound to the top level
// ----------------------------------------------------------------------------
module tcc_check (
    input logic              clk,
    input logic              rst_n,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input tcc_pkg::tcc_out_t out_data
);
    import tcc_pkg::*;

    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow output backpressure");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("held result changed before transfer");

    a_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.degenerate |->
            out_data.out_x == '0 && out_data.out_y == '0 &&
            out_data.out_z == '0 && !out_data.overflow)
        else $error("degenerate result not cleared");

    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.overflow |->
            out_data.out_x == {1'b1, {(CW-1){1'b0}}} ||
            out_data.out_x == {1'b0, {(CW-1){1'b1}}} ||
            out_data.out_y == {1'b1, {(CW-1){1'b0}}} ||
            out_data.out_y == {1'b0, {(CW-1){1'b1}}} ||
            out_data.out_z == {1'b1, {(CW-1){1'b0}}} ||
            out_data.out_z == {1'b0, {(CW-1){1'b1}}})
        else $error("overflow without a saturated coordinate");

endmodule

bind tetrahedron_circumcenter tcc_check u_check (.*);

### tb/tcc_checker.sv
// ----------------------------------------------------------------------------
// tcc_checker
// watches both channels of the circumcenter pipeline, predicts each result
// with exact wide integer arithmetic and compares it field by field
// ----------------------------------------------------------------------------
module tcc_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  tcc_pkg::tcc_in_t  in_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  tcc_pkg::tcc_out_t out_data,
    output int                errors,
    output int                pending,
    output int                n_deg,
    output int                n_ovf,
    output int                n_out
);
    import tcc_pkg::*;

    typedef logic signed [255:0] wide_t;

    tcc_out_t centers_q[$];

    function automatic logic signed [CW-1:0] clamp_coord(input wide_t v, inout logic ovf);
        wide_t hi;
        wide_t lo;
        hi = (wide_t'(1) <<< (CW - 1)) - 1;
        lo = -(wide_t'(1) <<< (CW - 1));
        if (v > hi)
        begin
            ovf = 1'b1;
            return hi[CW-1:0];
        end
        if (v < lo)
        begin
            ovf = 1'b1;
            return lo[CW-1:0];
        end
        return v[CW-1:0];
    endfunction

    function automatic tcc_out_t circumcenter(input tcc_in_t t);
        wide_t a[3], u[3], w[3], e[3], c1[3], c2[3], c3[3];
        wide_t su, sw, se, den, num, an, ad, q;
        logic ovf;
        tcc_out_t r;
        a[0] = t.a_x; a[1] = t.a_y; a[2] = t.a_z;
        u[0] = wide_t'(t.b_x) - a[0]; u[1] = wide_t'(t.b_y) - a[1];
        u[2] = wide_t'(t.b_z) - a[2];
        w[0] = wide_t'(t.c_x) - a[0]; w[1] = wide_t'(t.c_y) - a[1];
        w[2] = wide_t'(t.c_z) - a[2];
        e[0] = wide_t'(t.d_x) - a[0]; e[1] = wide_t'(t.d_y) - a[1];
        e[2] = wide_t'(t.d_z) - a[2];
        for (int k = 0; k < 3; k++)
        begin
            c1[k] = u[(k+1)%3] * w[(k+2)%3] - u[(k+2)%3] * w[(k+1)%3];
            c2[k] = e[(k+1)%3] * u[(k+2)%3] - e[(k+2)%3] * u[(k+1)%3];
            c3[k] = w[(k+1)%3] * e[(k+2)%3] - w[(k+2)%3] * e[(k+1)%3];
        end
        su = u[0]*u[0] + u[1]*u[1] + u[2]*u[2];
        sw = w[0]*w[0] + w[1]*w[1] + w[2]*w[2];
        se = e[0]*e[0] + e[1]*e[1] + e[2]*e[2];
        den = 2 * (u[0]*c3[0] + u[1]*c3[1] + u[2]*c3[2]);
        r = '0;
        if (den == 0)
        begin
            r.degenerate = 1'b1;
            return r;
        end
        ovf = 1'b0;
        ad = den < 0 ? -den : den;
        for (int k = 0; k < 3; k++)
        begin
            num = c1[k] * se + c2[k] * sw + c3[k] * su;
            an = num < 0 ? -num : num;
            q = (2 * an + ad) / (2 * ad);
            if ((num < 0) != (den < 0))
                q = -q;
            q = q + a[k];
            if (k == 0) r.out_x = clamp_coord(q, ovf);
            if (k == 1) r.out_y = clamp_coord(q, ovf);
            if (k == 2) r.out_z = clamp_coord(q, ovf);
        end
        r.overflow = ovf;
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        tcc_out_t want;
        if (!rst_n)
        begin
            errors  <= 0;
            pending <= 0;
            n_deg   <= 0;
            n_ovf   <= 0;
            n_out   <= 0;
            centers_q.delete();
        end
        else
        begin
            if (in_valid && in_ready)
                centers_q.push_back(circumcenter(in_data));
            if (out_valid && out_ready)
            begin
                n_out <= n_out + 1;
                n_deg <= n_deg + out_data.degenerate;
                n_ovf <= n_ovf + out_data.overflow;
                if (centers_q.size() == 0)
                begin
                    $display("%0t: unexpected transfer, actual %h", $time, out_data);
                    errors <= errors + 1;
                end
                else
                begin
                    want = centers_q.pop_front();
                    if (want.out_x !== out_data.out_x || want.out_y !== out_data.out_y
                        || want.out_z !== out_data.out_z
                        || want.degenerate !== out_data.degenerate
                        || want.overflow !== out_data.overflow)
                    begin
                        $display("%0t: mismatch expected x=%h y=%h z=%h deg=%b ovf=%b",
                                 $time, want.out_x, want.out_y, want.out_z,
                                 want.degenerate, want.overflow);
                        $display("%0t:          actual   x=%h y=%h z=%h deg=%b ovf=%b",
                                 $time, out_data.out_x, out_data.out_y, out_data.out_z,
                                 out_data.degenerate, out_data.overflow);
                        errors <= errors + 1;
                    end
                end
            end
            pending <= centers_q.size();
        end
    end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus for the tetrahedron circumcenter pipeline: directed corner cases,
// random tetrahedra of mixed scale, random stalls on both sides
// ----------------------------------------------------------------------------
module tb;
    import tcc_pkg::*;

    localparam int N_RANDOM = 1280;
    localparam int WD_LIMIT = 2000;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    tcc_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    tcc_out_t out_data;
    int       errors, pending, n_deg, n_ovf, n_out;
    int       n_sent;
    int       idle_cycles;
    logic     hold_sink;
    logic     sink_long;

    tetrahedron_circumcenter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    tcc_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .errors    (errors),
        .pending   (pending),
        .n_deg     (n_deg),
        .n_ovf     (n_ovf),
        .n_out     (n_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [CW-1:0] rand_coord(input int scale);
        logic [CW-1:0] v;
        v = $urandom;
        case (scale)
            0: v = {{20{v[11]}}, v[11:0]};
            1: v = {{12{v[19]}}, v[19:0]};
            2: v = {{6{v[25]}}, v[25:0]};
            default: ;
        endcase
        return v;
    endfunction

    function automatic tcc_in_t rand_tetra();
        tcc_in_t t;
        int sc;
        logic [CW-1:0] base;
        sc = $urandom_range(0, 3);
        base = $urandom;
        t = {rand_coord(sc), rand_coord(sc), rand_coord(sc), rand_coord(sc),
             rand_coord(sc), rand_coord(sc), rand_coord(sc), rand_coord(sc),
             rand_coord(sc), rand_coord(sc), rand_coord(sc), rand_coord(sc)};
        case ($urandom_range(0, 9))
            0:
            begin
                // flat: d in the plane of a, b, c
                t.d_x = t.b_x + t.c_x - t.a_x;
                t.d_y = t.b_y + t.c_y - t.a_y;
                t.d_z = t.b_z + t.c_z - t.a_z;
            end
            1:
            begin
                // tetrahedron shifted along x by a random offset
                t.a_x += base; t.b_x += base; t.c_x += base; t.d_x += base;
            end
            2:
            begin
                // repeated vertex
                t.c_x = t.a_x; t.c_y = t.a_y; t.c_z = t.a_z;
            end
            default: ;
        endcase
        return t;
    endfunction

    task automatic send(input tcc_in_t t, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 7) : 0;
        if (gap != 0)
            in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        in_valid <= 1'b1;
        in_data  <= t;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        n_sent++;
        if (gaps && $urandom_range(0, 1))
            in_valid <= 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // receiver: random stalls, or a long hold-off on request
    initial
    begin
        int w;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_sink)
            begin
                out_ready <= 1'b0;
                repeat (150) @(posedge clk);
                sink_long <= 1'b1;
                out_ready <= 1'b1;
                while (hold_sink) @(posedge clk);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                w = $urandom_range(0, 7);
                out_ready <= 1'b0;
                repeat (w) @(posedge clk);
                out_ready <= 1'b1;
                @(posedge clk);
                while (!out_valid) @(posedge clk);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding", pending);
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        tcc_in_t t;
        logic [CW-1:0] mx, mn;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        hold_sink   = 1'b0;
        sink_long   = 1'b0;
        n_sent      = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        mx = 32'h7fffffff;
        mn = 32'h80000000;
        // all vertices equal
        send('0, 0);
        send({12{mx}}, 0);
        // unit right-angle tetrahedron
        t = '0; t.b_x = 32'h10000; t.c_y = 32'h10000; t.d_z = 32'h10000;
        send(t, 0);
        // extreme corners, saturating result
        t = '0; t.a_x = mn; t.a_y = mn; t.a_z = mn;
        t.b_x = mx; t.b_y = mn; t.b_z = mn;
        t.c_x = mn; t.c_y = mx; t.c_z = mn;
        t.d_x = mn; t.d_y = mn; t.d_z = mx;
        send(t, 0);
        t.a_x = mx; t.a_y = mx; t.a_z = mx;
        send(t, 0);
        // nearly flat, big circumcenter
        t = '0; t.b_x = mx; t.c_y = mx; t.d_x = 32'h40000000; t.d_y = 32'h40000000;
        t.d_z = 32'h1;
        send(t, 0);
        t.d_z = 32'hffffffff;
        send(t, 0);
        // collinear points
        t = '0; t.b_x = 32'h1; t.c_x = 32'h2; t.d_x = 32'h3;
        send(t, 0);
        // tiny tetrahedron, rounding ties
        t = '0; t.b_x = 32'h1; t.c_y = 32'h1; t.d_z = 32'h1;
        send(t, 0);
        t = '0; t.b_x = 32'h3; t.c_y = 32'h1; t.d_z = 32'h1;
        send(t, 0);
        t = {mn, mx, mn, mx, mn, mx, mn, mx, mn, mx, mn, mx};
        send(t, 0);
        t = {32'h55555555, 32'haaaaaaaa, 32'h33333333, 32'hcccccccc,
             32'h0f0f0f0f, 32'hf0f0f0f0, 32'h00ff00ff, 32'hff00ff00,
             32'h12345678, 32'hedcba987, 32'h7f7f7f7f, 32'h80808080};
        send(t, 0);
        send(~t, 0);
        for (int i = 0; i < 8; i++)
            send({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom, $urandom, $urandom}, 0);
        drain();

        // long receiver hold-off while the sender keeps going
        hold_sink <= 1'b1;
        while (!sink_long)
            send(rand_tetra(), 0);
        hold_sink <= 1'b0;
        sink_long <= 1'b0;

        for (int i = 0; i < N_RANDOM; i++)
        begin
            send(rand_tetra(), (i / 200) % 3 != 1);
            if (i == N_RANDOM / 2)
                drain();
        end
        drain();
        repeat (60) @(posedge clk);

        $display("%0d tetrahedra sent, %0d results checked (%0d flat, %0d saturated)",
                 n_sent, n_out, n_deg, n_ovf);
        if (errors == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
hw/rtl/tcc_pkg.sv
hw/rtl/tcc_front.sv
hw/rtl/tcc_norm.sv
hw/rtl/tcc_div_stage.sv
hw/rtl/tetrahedron_circumcenter.sv
hw/rtl/tcc_check.sv
tb/tcc_checker.sv
tb/tb.sv
